// ===== rtl/core/lfda_pkg.sv =====
// Shared types and constants of the lidar frame distance average core.
// Holds widths, reset values, register indexes and the batch record type.
// No dependencies; every other file of the core refers to it by scoped names.
`default_nettype none

package lfda_pkg;

   // Bytes of one batch that take part in parsing; later bytes are dropped.
   localparam int BATCH_MAX_BYTES = 128;
   localparam int BATCH_CNT_W     = $clog2(BATCH_MAX_BYTES + 1);

   localparam int BYTE_W   = 8;
   localparam int STRIDE_W = 5;
   localparam int POS_W    = 4;
   localparam int DIST_W   = 16;
   localparam int SUM_W    = 22;
   localparam int CNT_W    = 7;
   localparam int STEP_W   = $clog2(SUM_W);

   localparam logic [BYTE_W-1:0]   SYNC_RESET   = 8'h59;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 5'd9;
   localparam logic [STRIDE_W-1:0] STRIDE_MIN   = 5'd2;
   localparam logic [STRIDE_W-1:0] STRIDE_MAX   = 5'd16;
   localparam logic [CNT_W-1:0]    PAIR_LIMIT   = 7'd64;

   // Configuration register indexes.
   typedef enum logic {
      CSR_SYNC_BYTE    = 1'b0,
      CSR_FRAME_STRIDE = 1'b1
   } csr_index_type;

   // Totals of one finished batch, handed from the parser to the divider.
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
   } batch_type;

   // Fill status of the batch queue.
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/lfda_front.sv =====
// Byte parser of the lidar frame distance average core: sync hunt, distance pair
// extraction and running totals. Holds the configuration registers.
// Depends on lfda_pkg.
`default_nettype none

module lfda_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire lfda_pkg::csr_index_type       csr_index,
   input  wire logic [lfda_pkg::BYTE_W-1:0]   csr_write_data,
   input  wire logic                          accept,
   input  wire logic [lfda_pkg::BYTE_W-1:0]   rx_byte,
   input  wire logic                          batch_last,
   output logic                               push,
   output lfda_pkg::batch_type                push_batch
);

   logic [lfda_pkg::BYTE_W-1:0]      sync_byte_ff;
   logic [lfda_pkg::STRIDE_W-1:0]    frame_stride_ff;

   logic                             synced_ff, synced_in;
   logic                             prev_sync_ff, prev_sync_in;
   logic [lfda_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [lfda_pkg::BYTE_W-1:0]      low_ff, low_in;
   logic [lfda_pkg::SUM_W-1:0]       sum_ff, sum_in;
   logic [lfda_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [lfda_pkg::BATCH_CNT_W-1:0] bytes_ff, bytes_in;

   logic [lfda_pkg::STRIDE_W-1:0]    stride_eff;
   logic [lfda_pkg::STRIDE_W-1:0]    pos_plus;
   logic                             in_range;
   logic                             is_sync;
   logic                             byte_add;
   logic                             dangle_add;
   logic [lfda_pkg::DIST_W-1:0]      pair_value;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_byte_ff    <= lfda_pkg::SYNC_RESET;
         frame_stride_ff <= lfda_pkg::STRIDE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lfda_pkg::CSR_SYNC_BYTE: begin
               sync_byte_ff <= csr_write_data;
            end
            lfda_pkg::CSR_FRAME_STRIDE: begin
               frame_stride_ff <= csr_write_data[lfda_pkg::STRIDE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (frame_stride_ff < lfda_pkg::STRIDE_MIN) begin
         stride_eff = lfda_pkg::STRIDE_MIN;
      end else if (frame_stride_ff > lfda_pkg::STRIDE_MAX) begin
         stride_eff = lfda_pkg::STRIDE_MAX;
      end else begin
         stride_eff = frame_stride_ff;
      end
   end

   assign pos_plus = {1'b0, pos_ff} + 5'd1;
   assign in_range = bytes_ff < lfda_pkg::BATCH_CNT_W'(lfda_pkg::BATCH_MAX_BYTES);
   assign is_sync  = (rx_byte == sync_byte_ff);

   always_comb begin
      synced_in    = synced_ff;
      prev_sync_in = prev_sync_ff;
      pos_in       = pos_ff;
      low_in       = low_ff;
      bytes_in     = bytes_ff;
      byte_add     = 1'b0;

      if (in_range) begin
         bytes_in = bytes_ff + 1'b1;
         if (!synced_ff) begin
            if (is_sync && prev_sync_ff) begin
               synced_in = 1'b1;
               pos_in    = '0;
            end
            prev_sync_in = is_sync;
         end else begin
            if (pos_ff == 4'd0) begin
               low_in = rx_byte;
            end else if (pos_ff == 4'd1) begin
               byte_add = 1'b1;
            end
            if (pos_plus >= stride_eff) begin
               pos_in = '0;
            end else begin
               pos_in = pos_plus[lfda_pkg::POS_W-1:0];
            end
         end
      end

      // A low byte still waiting for its high byte at batch end pairs with zero.
      // It cannot coincide with a byte completing a pair in the same transfer.
      dangle_add = batch_last && synced_in && (pos_in == 4'd1);
      pair_value = {(byte_add ? rx_byte : 8'd0), low_in};

      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if ((byte_add || dangle_add) && (cnt_ff < lfda_pkg::PAIR_LIMIT)) begin
         sum_in = sum_ff + {{(lfda_pkg::SUM_W - lfda_pkg::DIST_W){1'b0}}, pair_value};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   assign push             = accept && batch_last;
   assign push_batch.sum   = sum_in;
   assign push_batch.count = cnt_in;

   always_ff @(posedge clock) begin
      if (reset || push) begin
         synced_ff    <= 1'b0;
         prev_sync_ff <= 1'b0;
         pos_ff       <= '0;
         low_ff       <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         bytes_ff     <= '0;
      end else if (accept) begin
         synced_ff    <= synced_in;
         prev_sync_ff <= prev_sync_in;
         pos_ff       <= pos_in;
         low_ff       <= low_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         bytes_ff     <= bytes_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/lfda_queue.sv =====
// Two-entry queue of finished batch totals between parser and divider.
// Depends on lfda_pkg.
`default_nettype none

module lfda_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire lfda_pkg::batch_type       push_batch,
   input  wire logic                      pop,
   output lfda_pkg::batch_type            head,
   output lfda_pkg::queue_status_type     status
);

   lfda_pkg::batch_type entry_ff [2];
   logic                wr_ptr_ff;
   logic                rd_ptr_ff;
   logic [1:0]          fill_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_batch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   fill_ff <= fill_ff + 2'd1;
            2'b01:   fill_ff <= fill_ff - 2'd1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.empty = (fill_ff == 2'd0);
   assign status.full  = (fill_ff == 2'd2);

endmodule

`default_nettype wire

// ===== rtl/core/lfda_back.sv =====
// Averaging back end: takes batch totals from the queue, divides the sum by the
// pair count one quotient bit per cycle and holds the result for transfer.
// Depends on lfda_pkg.
`default_nettype none

module lfda_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire lfda_pkg::batch_type            head,
   input  wire lfda_pkg::queue_status_type     status,
   output logic                                pop,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [lfda_pkg::DIST_W-1:0]         rsp_avg_distance,
   output logic [lfda_pkg::CNT_W-1:0]          rsp_frame_count,
   output logic                                rsp_no_data
);

   typedef enum logic [1:0] {
      BACK_IDLE = 2'b01,
      BACK_DIV  = 2'b10
   } back_state_type;

   back_state_type                 state_ff, state_in;
   logic [lfda_pkg::SUM_W-1:0]     dvd_ff;
   logic [lfda_pkg::SUM_W-1:0]     quo_ff;
   logic [lfda_pkg::CNT_W-1:0]     rem_ff;
   logic [lfda_pkg::CNT_W-1:0]     div_ff;
   logic [lfda_pkg::STEP_W-1:0]    step_ff;

   logic                           rsp_valid_ff;
   logic [lfda_pkg::DIST_W-1:0]    avg_ff;
   logic [lfda_pkg::CNT_W-1:0]     cnt_ff;
   logic                           no_data_ff;

   logic [lfda_pkg::CNT_W:0]       trial;
   logic [lfda_pkg::CNT_W:0]       trial_sub;
   logic                           fits;
   logic                           last_step;
   logic [lfda_pkg::SUM_W-1:0]     quo_next;

   assign pop       = (state_ff == BACK_IDLE) && !status.empty && !rsp_valid_ff;
   assign trial     = {rem_ff, dvd_ff[lfda_pkg::SUM_W-1]};
   assign trial_sub = trial - {1'b0, div_ff};
   assign fits      = (trial >= {1'b0, div_ff});
   assign last_step = (step_ff == lfda_pkg::STEP_W'(lfda_pkg::SUM_W - 1));
   assign quo_next  = {quo_ff[lfda_pkg::SUM_W-2:0], fits};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (pop && (head.count != '0)) begin
               state_in = BACK_DIV;
            end
         end
         BACK_DIV: begin
            if (last_step) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Restoring division datapath.
   always_ff @(posedge clock) begin
      if (pop) begin
         dvd_ff  <= head.sum;
         div_ff  <= head.count;
         rem_ff  <= '0;
         quo_ff  <= '0;
         step_ff <= '0;
      end else if (state_ff == BACK_DIV) begin
         dvd_ff  <= {dvd_ff[lfda_pkg::SUM_W-2:0], 1'b0};
         rem_ff  <= fits ? trial_sub[lfda_pkg::CNT_W-1:0] : trial[lfda_pkg::CNT_W-1:0];
         quo_ff  <= quo_next;
         step_ff <= step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop && (head.count == '0)) begin
         rsp_valid_ff <= 1'b1;
      end else if ((state_ff == BACK_DIV) && last_step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && (head.count == '0)) begin
         avg_ff     <= '0;
         cnt_ff     <= '0;
         no_data_ff <= 1'b1;
      end else if ((state_ff == BACK_DIV) && last_step) begin
         avg_ff     <= quo_next[lfda_pkg::DIST_W-1:0];
         cnt_ff     <= div_ff;
         no_data_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_avg_distance = avg_ff;
   assign rsp_frame_count  = cnt_ff;
   assign rsp_no_data      = no_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lidar_frame_distance_average_core.sv =====
// Lidar frame distance average core: byte parser, batch queue and divider back end.
// Bytes transfer at one per cycle unless req_stall is high. The bit-serial divider
// averages one batch at a time, while the queue lets the bytes of later batches
// stream in. A batch without distance pairs skips the divider.
// Reset is synchronous and active high; it restores default registers and empties
// all batch state. Depends on lfda_pkg, lfda_front, lfda_queue and lfda_back.
`default_nettype none

module lidar_frame_distance_average_core (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          csr_write_enable,
   input  wire logic                          csr_index,
   input  wire logic [lfda_pkg::BYTE_W-1:0]   csr_write_data,

   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [lfda_pkg::BYTE_W-1:0]   req_rx_byte,
   input  wire logic                          req_batch_last,

   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [lfda_pkg::DIST_W-1:0]        rsp_avg_distance,
   output logic [lfda_pkg::CNT_W-1:0]         rsp_frame_count,
   output logic                               rsp_no_data
);

   // The parser works on every byte in the cycle it transfers and only needs
   // room in the queue when a batch ends. It stalls whenever the queue is full,
   // which only happens when two finished batches wait for the divider.
   logic                         accept;
   logic                         push;
   logic                         pop;
   lfda_pkg::batch_type          push_batch;
   lfda_pkg::batch_type          head;
   lfda_pkg::queue_status_type   status;

   assign req_stall = status.full;
   assign accept    = req_valid && !req_stall;

   lfda_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (lfda_pkg::csr_index_type'(csr_index)),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .rx_byte          (req_rx_byte),
      .batch_last       (req_batch_last),
      .push             (push),
      .push_batch       (push_batch)
   );

   // The queue decouples byte parsing from the long division, so a new batch
   // can stream in while the previous one is still being averaged.
   lfda_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_batch (push_batch),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   // The back end pops one batch at a time, only while its output register is
   // free, and divides the distance sum by the pair count one bit per cycle.
   lfda_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .status           (status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_avg_distance (rsp_avg_distance),
      .rsp_frame_count  (rsp_frame_count),
      .rsp_no_data      (rsp_no_data)
   );

   // A batch end must never arrive at a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("batch queue overflow");

   // The no-data flag matches an empty pair count.
   a_no_data_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_no_data == (rsp_frame_count == '0)))
      else $error("no_data disagrees with frame_count");

   // An empty batch reports a zero average.
   a_no_data_avg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_data) |-> (rsp_avg_distance == '0))
      else $error("empty batch with nonzero average");

   // The pair count never exceeds the pair limit.
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_count <= lfda_pkg::PAIR_LIMIT))
      else $error("frame_count beyond pair limit");

   // Nothing is popped while a result still waits to transfer.
   a_pop_free: assert property (@(posedge clock) disable iff (reset)
      pop |-> !rsp_valid)
      else $error("pop while result pending");

endmodule

`default_nettype wire

// ===== dv/lfda_average_checker.sv =====
// Scoreboard for the lidar frame distance average core: tracks register writes,
// predicts one average per batch from the transferred bytes and compares the results.
// Depends on lfda_pkg for widths, reset values and register indexes.
`default_nettype none

module lfda_average_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire lfda_pkg::csr_index_type       csr_index,
   input  wire logic [lfda_pkg::BYTE_W-1:0]   csr_write_data,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic [lfda_pkg::BYTE_W-1:0]   req_rx_byte,
   input  wire logic                          req_batch_last,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [lfda_pkg::DIST_W-1:0]   rsp_avg_distance,
   input  wire logic [lfda_pkg::CNT_W-1:0]    rsp_frame_count,
   input  wire logic                          rsp_no_data,
   output int                                 error_count,
   output int                                 due_count,
   output int                                 checked_count,
   output int                                 empty_count
);

   typedef struct packed {
      logic [lfda_pkg::DIST_W-1:0] avg;
      logic [lfda_pkg::CNT_W-1:0]  count;
      logic                        no_data;
   } frame_average_type;

   frame_average_type averages_due[$];

   logic [lfda_pkg::BYTE_W-1:0]   sync_cfg;
   logic [lfda_pkg::STRIDE_W-1:0] stride_cfg;

   logic                        synced;
   logic                        prev_sync;
   logic [lfda_pkg::POS_W-1:0]  pos;
   logic [lfda_pkg::BYTE_W-1:0] low_hold;
   logic [lfda_pkg::SUM_W-1:0]  sum;
   logic [lfda_pkg::CNT_W-1:0]  pairs;
   int                          bytes_taken;

   function automatic logic [lfda_pkg::STRIDE_W-1:0] stride_span();
      if (stride_cfg < lfda_pkg::STRIDE_MIN) return lfda_pkg::STRIDE_MIN;
      if (stride_cfg > lfda_pkg::STRIDE_MAX) return lfda_pkg::STRIDE_MAX;
      return stride_cfg;
   endfunction

   task automatic restart_batch();
      synced      = 1'b0;
      prev_sync   = 1'b0;
      pos         = '0;
      low_hold    = '0;
      sum         = '0;
      pairs       = '0;
      bytes_taken = 0;
   endtask

   // Pairs past the limit are dropped so the sum cannot overflow.
   task automatic add_distance(input logic [lfda_pkg::BYTE_W-1:0] high);
      if (pairs < lfda_pkg::PAIR_LIMIT) begin
         sum   = sum + {high, low_hold};
         pairs = pairs + 1'b1;
      end
   endtask

   task automatic parse_byte(input logic [lfda_pkg::BYTE_W-1:0] b, input logic last);
      frame_average_type          due;
      logic [lfda_pkg::SUM_W-1:0] mean;
      if (bytes_taken < lfda_pkg::BATCH_MAX_BYTES) begin
         bytes_taken++;
         if (!synced) begin
            if (b == sync_cfg && prev_sync) begin
               synced = 1'b1;
               pos    = '0;
            end
            prev_sync = (b == sync_cfg);
         end else begin
            if (pos == 0) low_hold = b;
            else if (pos == 1) add_distance(b);
            // A stride lowered under the current position wraps on this byte.
            if (int'(pos) + 1 >= int'(stride_span())) pos = '0;
            else pos = pos + 1'b1;
         end
      end
      if (last) begin
         // A low byte without its high byte is closed with a zero high byte.
         if (synced && pos == 1) add_distance('0);
         if (pairs == 0) begin
            due.avg     = '0;
            due.count   = '0;
            due.no_data = 1'b1;
         end else begin
            mean        = sum / pairs;
            due.avg     = mean[lfda_pkg::DIST_W-1:0];
            due.count   = pairs;
            due.no_data = 1'b0;
         end
         averages_due.push_back(due);
         restart_batch();
      end
   endtask

   task automatic compare_result();
      frame_average_type due;
      if (averages_due.size() == 0) begin
         $error("unexpected result: avg_distance %0d frame_count %0d no_data %0d",
                rsp_avg_distance, rsp_frame_count, rsp_no_data);
         error_count++;
      end else begin
         due = averages_due.pop_front();
         checked_count++;
         if (due.no_data) empty_count++;
         if (rsp_avg_distance !== due.avg) begin
            $error("avg_distance: expected %0d, actual %0d", due.avg, rsp_avg_distance);
            error_count++;
         end
         if (rsp_frame_count !== due.count) begin
            $error("frame_count: expected %0d, actual %0d", due.count, rsp_frame_count);
            error_count++;
         end
         if (rsp_no_data !== due.no_data) begin
            $error("no_data: expected %0d, actual %0d", due.no_data, rsp_no_data);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sync_cfg      = lfda_pkg::SYNC_RESET;
         stride_cfg    = lfda_pkg::STRIDE_RESET;
         restart_batch();
         averages_due.delete();
         error_count   = 0;
         checked_count = 0;
         empty_count   = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               lfda_pkg::CSR_SYNC_BYTE:    sync_cfg = csr_write_data;
               lfda_pkg::CSR_FRAME_STRIDE: stride_cfg = csr_write_data[lfda_pkg::STRIDE_W-1:0];
               default:                    ;
            endcase
         end
         if (req_valid && !req_stall) parse_byte(req_rx_byte, req_batch_last);
         if (rsp_valid && !rsp_stall) compare_result();
      end
      due_count = averages_due.size();
   end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Top of the lidar frame distance average testbench: clock, reset, register writes,
// byte batches, result-side stalls, watchdog and verdict.
// Depends on lfda_pkg, lidar_frame_distance_average_core and lfda_average_checker.
`default_nettype none

module tb;

   // Longest stretch without any transfer before the run is declared hung.
   // A correct run never gets near it: every divider run and every stall or gap
   // burst is much shorter.
   localparam int IDLE_LIMIT   = 4000;
   // Cycles to wait after the last expected result, more than the divider takes.
   localparam int DRAIN_CYCLES = 30;
   // Bytes parsed by the end of the random phases, spread evenly over them.
   localparam int ITEM_GOAL    = 850;
   localparam int PHASES       = 8;

   logic                              clock            = 1'b0;
   logic                              reset            = 1'b1;
   logic                              csr_write_enable = 1'b0;
   lfda_pkg::csr_index_type           csr_index        = lfda_pkg::CSR_SYNC_BYTE;
   logic [lfda_pkg::BYTE_W-1:0]       csr_write_data   = '0;
   logic                              req_valid        = 1'b0;
   logic                              req_stall;
   logic [lfda_pkg::BYTE_W-1:0]       req_rx_byte      = '0;
   logic                              req_batch_last   = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall        = 1'b0;
   logic [lfda_pkg::DIST_W-1:0]       rsp_avg_distance;
   logic [lfda_pkg::CNT_W-1:0]        rsp_frame_count;
   logic                              rsp_no_data;

   int error_count;
   int due_count;
   int checked_count;
   int empty_count;

   // Register values as last written, used to shape the batches.
   logic [lfda_pkg::BYTE_W-1:0]   cur_sync   = lfda_pkg::SYNC_RESET;
   logic [lfda_pkg::STRIDE_W-1:0] cur_stride = lfda_pkg::STRIDE_RESET;

   // Percent chance that a transfer is preceded by a gap, and that the result
   // side starts a stall burst. Zero gives stretches with no idling at all.
   int idle_pct   = 0;
   int stall_left = 0;

   int items_used   = 0;
   int batch_pos    = 0;
   int batches_sent = 0;
   int stuck_cycles = 0;

   logic [lfda_pkg::BYTE_W-1:0] batch_q[$];

   always #4 clock = ~clock;

   lidar_frame_distance_average_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .req_batch_last   (req_batch_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_avg_distance (rsp_avg_distance),
      .rsp_frame_count  (rsp_frame_count),
      .rsp_no_data      (rsp_no_data)
   );

   lfda_average_checker average_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .req_batch_last   (req_batch_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_avg_distance (rsp_avg_distance),
      .rsp_frame_count  (rsp_frame_count),
      .rsp_no_data      (rsp_no_data),
      .error_count      (error_count),
      .due_count        (due_count),
      .checked_count    (checked_count),
      .empty_count      (empty_count)
   );

   // The result side stalls in random bursts. The stall only moves on the falling
   // edge, so the core sees it settled at every rising edge.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else if ($urandom_range(1, 100) <= idle_pct) begin
         stall_left = $urandom_range(1, 6);
      end
      rsp_stall <= (stall_left > 0);
   end

   // Watchdog: any transfer on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= IDLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   // Presents one byte at a falling edge and holds it until it transfers.
   // Entered and left at a falling edge; valid stays high on return, so the
   // next byte can follow without a gap.
   task automatic put_byte(input logic [lfda_pkg::BYTE_W-1:0] b, input logic last);
      if ($urandom_range(1, 100) <= idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_rx_byte    <= b;
      req_batch_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      // Bytes past the batch limit are dropped by the core and do not count.
      if (batch_pos < lfda_pkg::BATCH_MAX_BYTES) items_used++;
      batch_pos = last ? 0 : batch_pos + 1;
   endtask

   // Sends the queued bytes; the final one carries the batch end flag only when
   // the batch is to be closed here.
   task automatic send_batch(input bit close);
      for (int i = 0; i < batch_q.size(); i++) begin
         put_byte(batch_q[i], close && (i == batch_q.size() - 1));
      end
      if (close) batches_sent++;
   endtask

   // Drops valid and waits until every predicted average has arrived, then lets
   // the divider run out before the registers may be touched.
   task automatic settle();
      req_valid <= 1'b0;
      while (due_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Raises the write enable for one cycle per call; the caller lowers it after
   // the last write so that back-to-back writes never toggle it within a step.
   task automatic write_reg(input lfda_pkg::csr_index_type idx,
                            input logic [lfda_pkg::BYTE_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      if (idx == lfda_pkg::CSR_SYNC_BYTE) cur_sync = data;
      else cur_stride = data[lfda_pkg::STRIDE_W-1:0];
      @(negedge clock);
   endtask

   // Mostly plain random bytes, with the extremes and the sync value mixed in.
   function automatic logic [lfda_pkg::BYTE_W-1:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return cur_sync;
         default: return lfda_pkg::BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Builds one random batch. Most are well formed: a little noise, the sync
   // pair and a few frames with random content, often cut short so that the
   // batch ends on a low byte. Some are long enough to cross the batch limit,
   // the rest are noise or broken sync pairs.
   task automatic build_batch();
      int span;
      int kind;
      bit ones;
      span = (cur_stride < lfda_pkg::STRIDE_MIN) ? int'(lfda_pkg::STRIDE_MIN)
           : (cur_stride > lfda_pkg::STRIDE_MAX) ? int'(lfda_pkg::STRIDE_MAX)
           : int'(cur_stride);
      kind = $urandom_range(0, 99);
      batch_q.delete();
      if (kind < 66) begin
         repeat ($urandom_range(0, 3)) batch_q.push_back(pick_byte());
         batch_q.push_back(cur_sync);
         batch_q.push_back(cur_sync);
         repeat ($urandom_range(0, 3) * span + $urandom_range(0, span - 1)) begin
            batch_q.push_back(pick_byte());
         end
      end else if (kind < 72) begin
         // A leading odd byte moves the last low byte onto the limit at stride 2.
         repeat ($urandom_range(0, 1)) batch_q.push_back(~cur_sync);
         batch_q.push_back(cur_sync);
         batch_q.push_back(cur_sync);
         ones = $urandom_range(0, 1);
         repeat ($urandom_range(118, 138)) batch_q.push_back(ones ? 8'hFF : pick_byte());
      end else if (kind < 86) begin
         repeat ($urandom_range(1, 10)) begin
            batch_q.push_back($urandom_range(0, 1)
                              ? cur_sync : lfda_pkg::BYTE_W'($urandom_range(0, 255)));
         end
      end else begin
         batch_q.push_back(cur_sync);
         batch_q.push_back(cur_sync ^ lfda_pkg::BYTE_W'($urandom_range(1, 255)));
         repeat ($urandom_range(0, 3)) batch_q.push_back(pick_byte());
      end
   endtask

   initial begin
      logic [lfda_pkg::BYTE_W-1:0]   sync_val;
      logic [lfda_pkg::STRIDE_W-1:0] stride_val;
      bit                            last_phase;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed batches under the reset settings.
      idle_pct = 15;
      // A single byte: the empty batch reports no data.
      batch_q = '{8'h00};
      send_batch(1);
      // One distance at the top of the range.
      batch_q = '{lfda_pkg::SYNC_RESET, lfda_pkg::SYNC_RESET, 8'hFF, 8'hFF};
      send_batch(1);
      // A broken sync pair before the real one, then a zero distance.
      batch_q = '{lfda_pkg::SYNC_RESET, 8'h12, lfda_pkg::SYNC_RESET, lfda_pkg::SYNC_RESET,
                  8'h00, 8'h00, 8'h34};
      send_batch(1);
      // The batch ends right after a low byte, which is paired with a zero.
      batch_q = '{lfda_pkg::SYNC_RESET, lfda_pkg::SYNC_RESET, 8'hA7};
      send_batch(1);
      // The stride drops below the current frame position in the middle of a
      // batch; the next byte wraps the position and a second frame follows.
      batch_q = '{lfda_pkg::SYNC_RESET, lfda_pkg::SYNC_RESET, 8'h10, 8'h20,
                  8'h01, 8'h02, 8'h03, 8'h04};
      send_batch(0);
      settle();
      write_reg(lfda_pkg::CSR_FRAME_STRIDE, 8'd3);
      csr_write_enable <= 1'b0;
      batch_q = '{8'h55, 8'h34, 8'h12};
      send_batch(1);

      // Random phases, each under its own register setting. The extremes of
      // both registers come first, including strides outside the legal range.
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         sync_val = lfda_pkg::BYTE_W'($urandom_range(0, 255));
         case (ph)
            0: begin
               sync_val   = 8'h00;
               stride_val = 5'd0;
            end
            1: begin
               sync_val   = 8'hFF;
               stride_val = 5'd31;
            end
            2: begin
               sync_val   = lfda_pkg::SYNC_RESET;
               stride_val = lfda_pkg::STRIDE_MIN;
            end
            3: begin
               sync_val   = 8'hA5;
               stride_val = lfda_pkg::STRIDE_MAX;
            end
            4:       stride_val = 5'd1;
            5:       stride_val = 5'd17;
            6:       stride_val = lfda_pkg::STRIDE_W'($urandom_range(2, 16));
            default: begin
               sync_val   = lfda_pkg::SYNC_RESET;
               stride_val = lfda_pkg::STRIDE_RESET;
            end
         endcase
         write_reg(lfda_pkg::CSR_SYNC_BYTE, sync_val);
         // The upper bits of the write data are random; the register keeps
         // only its low bits.
         write_reg(lfda_pkg::CSR_FRAME_STRIDE, {3'($urandom_range(0, 7)), stride_val});
         csr_write_enable <= 1'b0;

         last_phase = (ph == PHASES - 1);
         while (items_used < (ITEM_GOAL * (ph + 1)) / PHASES) begin
            // The closing phase runs with no idling on either side.
            idle_pct = last_phase ? 0 : ($urandom_range(0, 3) == 0 ? 0 : 20);
            build_batch();
            send_batch(1);
         end
      end

      settle();
      $display("tb: %0d bytes parsed in %0d batches under %0d register settings",
               items_used, batches_sent, PHASES + 2);
      $display("tb: %0d averages compared, %0d of them from batches without a frame",
               checked_count, empty_count);
      if (error_count == 0 && due_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== lidar_frame_distance_average_core.f =====
rtl/core/lfda_pkg.sv
rtl/core/lfda_front.sv
rtl/core/lfda_queue.sv
rtl/core/lfda_back.sv
rtl/core/lidar_frame_distance_average_core.sv
dv/lfda_average_checker.sv
dv/tb.sv
